// ===== sv/gcd_pkg.sv =====
// gcd_pkg: constants shared by the great-circle distance datapath.
// Fixed-point angle constants, sine polynomial reciprocals, sine stage count.
// No dependencies.
`default_nettype none

package gcd_pkg;

	localparam int SIN_LAT = 13;

	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
	localparam logic [31:0] PI_Q30      = 32'd3373259426;

	// floor(n / den) for n < 2^32 as (n * SIN_M) >> SIN_K
	localparam int unsigned SIN_K [5] = '{39, 39, 38, 37, 35};
	localparam logic [32:0] SIN_M [5] = '{
		33'(((64'd1 << 39) + 64'd109) / 64'd110),
		33'(((64'd1 << 39) + 64'd71) / 64'd72),
		33'(((64'd1 << 38) + 64'd41) / 64'd42),
		33'(((64'd1 << 37) + 64'd19) / 64'd20),
		33'(((64'd1 << 35) + 64'd5) / 64'd6)
	};

	// floor(x / 45): x < 2^26 with shift 32, x < 2^27 with shift 33
	localparam logic [26:0] DIV45_M1 = 27'(((64'd1 << 32) + 64'd44) / 64'd45);
	localparam logic [27:0] DIV45_M2 = 28'(((64'd1 << 33) + 64'd44) / 64'd45);

	localparam logic [23:0] RADIUS_RESET = 24'd1630976;
	localparam logic [23:0] DIST_MAX     = 24'hFFFFFF;

endpackage

`default_nettype wire

// ===== sv/gcd_sin.sv =====
// gcd_sin: pipelined sine of a 32-bit turn phase, Q30 result.
// Quadrant fold, Taylor polynomial to x^11, clamp.
// Depends on gcd_pkg.
`default_nettype none

module gcd_sin (
	input  logic               clk,
	input  logic               en,
	input  logic [31:0]        phase,
	output logic signed [31:0] sin_val
);

	logic [30:0] r_c;
	logic [30:0] rf_c;
	logic [30:0] x_c;
	logic [31:0] x2_c;
	logic [30:0] v_c;
	logic [30:0] mag_c;
	logic [31:0] n_c [5];
	logic [30:0] t_c [5];

	logic [61:0] rp_s0;
	logic [61:0] xx_s1;
	logic [61:0] fp_s11;
	logic        neg_s [0:11];
	logic [30:0] x_s [1:10];
	logic [31:0] x2_s [2:8];
	logic [64:0] dp_s [5];
	logic [61:0] tp_s [4];

	always_comb begin
		r_c   = {1'b0, phase[29:0]};
		rf_c  = phase[30] ? (31'h4000_0000 - r_c) : r_c;
		x_c   = 31'((rp_s0 + 62'h2000_0000) >> 30);
		x2_c  = 32'((xx_s1 + 62'h2000_0000) >> 30);
		n_c[0] = x2_c;
		for (int i = 1; i < 5; i++) begin
			n_c[i] = 32'((tp_s[i-1] + 62'h2000_0000) >> 30);
		end
		for (int i = 0; i < 5; i++) begin
			t_c[i] = 31'h4000_0000 - 31'(dp_s[i] >> gcd_pkg::SIN_K[i]);
		end
		v_c   = 31'((fp_s11 + 62'h2000_0000) >> 30);
		mag_c = (v_c > 31'h4000_0000) ? 31'h4000_0000 : v_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rp_s0     <= 62'(rf_c) * 62'(gcd_pkg::HALF_PI_Q30);
			neg_s[0]  <= phase[31];
			x_s[1]    <= x_c;
			xx_s1     <= 62'(x_c) * 62'(x_c);
			x2_s[2]   <= x2_c;
			for (int k = 1; k < 12; k++) begin
				neg_s[k] <= neg_s[k-1];
			end
			for (int k = 2; k < 11; k++) begin
				x_s[k] <= x_s[k-1];
			end
			for (int k = 3; k < 9; k++) begin
				x2_s[k] <= x2_s[k-1];
			end
			for (int i = 0; i < 5; i++) begin
				dp_s[i] <= 65'(n_c[i]) * 65'(gcd_pkg::SIN_M[i]);
			end
			for (int i = 0; i < 4; i++) begin
				tp_s[i] <= 62'(x2_s[2+2*i]) * 62'(t_c[i]);
			end
			fp_s11  <= 62'(x_s[10]) * 62'(t_c[4]);
			sin_val <= neg_s[11] ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
		end
	end

endmodule

`default_nettype wire

// ===== sv/great_circle_distance_unit.sv =====
// great_circle_distance_unit: haversine distance between two points, fully pipelined.
// Phase conversion, four sine lanes, haversine term, integer square root,
// arcsine bisection, radius scaling. Depends on gcd_pkg and gcd_sin.
//
// Usage:
//  - Input channel in_valid/in_ready carries from_lat, from_lon, to_lat, to_lon.
//  - Output channel out_valid/out_ready carries distance (km * 256, saturating).
//  - Config channel cfg_valid/cfg_ready writes sphere_radius; always ready;
//    the user must write it only while no request is in flight, and the block does not enforce this.
//  - One request enters every cycle while the output does not stall. The depth
//    is set by the 30 arcsine bisection steps, each a 13-stage sine pipeline
//    plus a compare stage, and the 32-stage square root.
//  - The whole pipeline advances together; when a result waits at the
//    output and out_ready is low, every stage holds and in_ready is low.
//  - Reset clears all valid bits and loads the 6371 km radius.
`default_nettype none

module great_circle_distance_unit #(
	parameter int ANGLE_FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [23:0] from_lat,
	input  logic signed [24:0] from_lon,
	input  logic signed [23:0] to_lat,
	input  logic signed [24:0] to_lon,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [23:0]        distance,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [23:0]        sphere_radius
);

	localparam int SL      = gcd_pkg::SIN_LAT;
	localparam int ISQ_END = 3 + SL + 3 + 32;
	localparam int BIS_END = ISQ_END + 30 * (SL + 1);
	localparam int LAT     = BIS_END + 3;

	function automatic logic [30:0] mag31(input logic signed [31:0] v);
		mag31 = v[31] ? 31'(-v) : v[30:0];
	endfunction

	logic             adv;
	logic [LAT-1:0]   vld_q;
	logic [23:0]      radius_q;

	assign adv       = !out_valid || out_ready;
	assign in_ready  = adv;
	assign out_valid = vld_q[LAT-1];
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			radius_q <= gcd_pkg::RADIUS_RESET;
		end else begin
			if (adv) begin
				vld_q <= {vld_q[LAT-2:0], in_valid};
			end
			if (cfg_valid) begin
				radius_q <= sphere_radius;
			end
		end
	end

	// degrees to phase, four lanes: half dlat, half dlon, lat1 and lat2 plus a quarter turn
	logic signed [25:0] d_c [4];
	logic [52:0]        pa_s1 [4];
	logic [25:0]        pm_s1 [4];
	logic               pn_s1 [4];
	logic [54:0]        py_s2 [4];
	logic [20:0]        pq_s2 [4];
	logic               pn_s2 [4];
	logic [31:0]        ph_s3 [4];
	logic signed [31:0] sin_s16 [4];

	assign d_c[0] = 26'(to_lat) - 26'(from_lat);
	assign d_c[1] = 26'(to_lon) - 26'(from_lon);
	assign d_c[2] = 26'(from_lat);
	assign d_c[3] = 26'(to_lat);

	for (genvar l = 0; l < 4; l++) begin : g_lane
		localparam int SHR = ((l < 2) ? 31 : 32) - ANGLE_FRAC_BITS - 3;
		logic [25:0] m_c;
		logic [20:0] a_c;
		logic [25:0] bf_c;
		logic [26:0] y_c;
		logic [21:0] q2_c;
		logic [31:0] qs_c;
		logic [31:0] ph_c;

		always_comb begin
			m_c  = d_c[l][25] ? 26'(-d_c[l]) : 26'(d_c[l]);
			a_c  = pa_s1[l][52:32];
			bf_c = pm_s1[l] - (26'(a_c) * 26'd45);
			y_c  = (27'(bf_c[5:0]) << SHR) + 27'd22;
			q2_c = py_s2[l][54:33];
			qs_c = (32'(pq_s2[l]) << SHR) + 32'(q2_c);
			ph_c = pn_s2[l] ? -qs_c : qs_c;
			if (l >= 2) begin
				ph_c = ph_c + 32'h4000_0000;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				pa_s1[l] <= 53'(m_c) * 53'(gcd_pkg::DIV45_M1);
				pm_s1[l] <= m_c;
				pn_s1[l] <= d_c[l][25];
				py_s2[l] <= 55'(y_c) * 55'(gcd_pkg::DIV45_M2);
				pq_s2[l] <= a_c;
				pn_s2[l] <= pn_s1[l];
				ph_s3[l] <= ph_c;
			end
		end

		gcd_sin u_sin (
			.clk     (clk),
			.en      (adv),
			.phase   (ph_s3[l]),
			.sin_val (sin_s16[l])
		);
	end

	// haversine term a = s1^2 + (c1 s2)(c2 s2), clamped to [0, 2^60]
	logic [61:0]        m1_s17, m2_s17, sq_s17;
	logic               n1_s17, n2_s17;
	logic [30:0]        w1m_c, w2m_c;
	logic signed [31:0] w1_c, w2_c;
	logic signed [63:0] wp_s18;
	logic [61:0]        sq_s18;
	logic signed [63:0] sum_c;
	logic [60:0]        a_s19;

	always_comb begin
		w1m_c = 31'((m1_s17 + 62'h2000_0000) >> 30);
		w2m_c = 31'((m2_s17 + 62'h2000_0000) >> 30);
		w1_c  = n1_s17 ? -$signed({1'b0, w1m_c}) : $signed({1'b0, w1m_c});
		w2_c  = n2_s17 ? -$signed({1'b0, w2m_c}) : $signed({1'b0, w2m_c});
		sum_c = $signed({2'b00, sq_s18}) + wp_s18;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m1_s17 <= 62'(mag31(sin_s16[2])) * 62'(mag31(sin_s16[1]));
			m2_s17 <= 62'(mag31(sin_s16[3])) * 62'(mag31(sin_s16[1]));
			sq_s17 <= 62'(mag31(sin_s16[0])) * 62'(mag31(sin_s16[0]));
			n1_s17 <= sin_s16[2][31] ^ sin_s16[1][31];
			n2_s17 <= sin_s16[3][31] ^ sin_s16[1][31];
			wp_s18 <= 64'(w1_c) * 64'(w2_c);
			sq_s18 <= sq_s17;
			if (sum_c < 0) begin
				a_s19 <= '0;
			end else if (sum_c > (64'sd1 <<< 60)) begin
				a_s19 <= 61'(64'd1 << 60);
			end else begin
				a_s19 <= 61'(sum_c);
			end
		end
	end

	// integer square root, one result bit per stage
	logic [60:0] isq_v_s [32];
	logic [63:0] isq_r_s [32];

	for (genvar k = 0; k < 32; k++) begin : g_isq
		logic [63:0] v_in, r_in, trial, bit_c;

		if (k == 0) begin : g_first
			assign v_in = 64'(a_s19);
			assign r_in = '0;
		end else begin : g_next
			assign v_in = 64'(isq_v_s[k-1]);
			assign r_in = isq_r_s[k-1];
		end
		assign bit_c = 64'd1 << (62 - 2 * k);
		assign trial = r_in + bit_c;

		always_ff @(posedge clk) begin
			if (adv) begin
				if (v_in >= trial) begin
					isq_v_s[k] <= 61'(v_in - trial);
					isq_r_s[k] <= (r_in >> 1) + bit_c;
				end else begin
					isq_v_s[k] <= 61'(v_in);
					isq_r_s[k] <= r_in >> 1;
				end
			end
		end
	end

	// arcsine by bisection on the quarter-turn phase
	logic [30:0] bis_lo_s [30];
	logic [30:0] bis_hi_s [30];
	logic [30:0] bis_rt_s [29];

	for (genvar j = 0; j < 30; j++) begin : g_bis
		logic [30:0]        lo_in, hi_in, rt_in, mid_c;
		logic signed [31:0] sv_c;
		logic               le_c;
		logic [30:0]        lo_s  [SL];
		logic [30:0]        hi_s  [SL];
		logic [30:0]        mid_s [SL];
		logic [30:0]        rt_s  [SL];

		if (j == 0) begin : g_first
			assign lo_in = '0;
			assign hi_in = 31'h4000_0000;
			assign rt_in = isq_r_s[31][30:0];
		end else begin : g_next
			assign lo_in = bis_lo_s[j-1];
			assign hi_in = bis_hi_s[j-1];
			assign rt_in = bis_rt_s[j-1];
		end
		assign mid_c = lo_in + ((hi_in - lo_in) >> 1);
		assign le_c  = sv_c <= $signed({1'b0, rt_s[SL-1]});

		gcd_sin u_sin (
			.clk     (clk),
			.en      (adv),
			.phase   ({1'b0, mid_c}),
			.sin_val (sv_c)
		);

		always_ff @(posedge clk) begin
			if (adv) begin
				lo_s[0]  <= lo_in;
				hi_s[0]  <= hi_in;
				mid_s[0] <= mid_c;
				rt_s[0]  <= rt_in;
				for (int k = 1; k < SL; k++) begin
					lo_s[k]  <= lo_s[k-1];
					hi_s[k]  <= hi_s[k-1];
					mid_s[k] <= mid_s[k-1];
					rt_s[k]  <= rt_s[k-1];
				end
				bis_lo_s[j] <= le_c ? mid_s[SL-1] : lo_s[SL-1];
				bis_hi_s[j] <= le_c ? hi_s[SL-1] : mid_s[SL-1];
			end
		end

		if (j < 29) begin : g_rt
			always_ff @(posedge clk) begin
				if (adv) begin
					bis_rt_s[j] <= rt_s[SL-1];
				end
			end
		end
	end

	// central angle and radius scaling
	logic [62:0] ang_s472;
	logic [31:0] ang_c;
	logic [55:0] dp_s473;
	logic [26:0] dist_c;
	logic [23:0] dist_s474;

	assign ang_c    = 32'((ang_s472 + 63'h2000_0000) >> 30);
	assign dist_c   = 27'((57'(dp_s473) + 57'h2000_0000) >> 30);
	assign distance = dist_s474;

	always_ff @(posedge clk) begin
		if (adv) begin
			ang_s472  <= 63'(bis_lo_s[29]) * 63'(gcd_pkg::PI_Q30);
			dp_s473   <= 56'(radius_q) * 56'(ang_c);
			dist_s474 <= (dist_c > 27'(gcd_pkg::DIST_MAX)) ? gcd_pkg::DIST_MAX : dist_c[23:0];
		end
	end

`ifndef SYNTHESIS
	a_stall_keeps_items: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> $countones(vld_q) == $past($countones(vld_q)))
		else $error("pipeline gained or lost an item while stalled");

	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[ISQ_END-1] |-> isq_r_s[31] <= 64'h4000_0000)
		else $error("square root above one");

	a_bisect_order: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[BIS_END-1] |-> bis_lo_s[29] < bis_hi_s[29])
		else $error("bisection bounds crossed");
`endif

endmodule

`default_nettype wire
